/* design/sttq_pkg.sv */
// shared types and constants for the sorted timer queue
// no dependencies
package sttq_pkg;

    localparam int unsigned TIMER_COUNT_DEF = 16;
    localparam int unsigned DL_W = 32;
    localparam int unsigned ID_W = 4;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SETUP = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    typedef struct packed {
        logic            valid;
        logic [DL_W-1:0] deadline;
        logic [ID_W-1:0] owner;
    } entry_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_MARK,
        OP_COMPACT,
        OP_SHIFT,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t        op;
        logic [ID_W-1:0] key;
        entry_t          fresh;
    } cell_ctl_t;

endpackage

/* design/sttq_cell.sv */
// one queue cell: holds one entry, trades with its left and right neighbors
// depends on sttq_pkg
module sttq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  sttq_pkg::cell_ctl_t ctl,
    input  sttq_pkg::entry_t   left_e,
    input  logic               left_gt,
    input  sttq_pkg::entry_t   right_e,
    output sttq_pkg::entry_t   self_e,
    output logic               self_gt
);
    import sttq_pkg::*;

    entry_t cell_reg;
    entry_t cell_next;

    assign self_e  = cell_reg;
    // empty cells sort after everything
    assign self_gt = !cell_reg.valid || (cell_reg.deadline > ctl.fresh.deadline);

    always_comb
    begin
        cell_next = cell_reg;
        unique case (ctl.op)
            OP_HOLD: cell_next = cell_reg;
            OP_MARK:
            begin
                if (cell_reg.valid && cell_reg.owner == ctl.key)
                    cell_next.valid = 1'b0;
            end
            OP_COMPACT:
            begin
                // holes bubble toward the tail one cell per cycle
                if (!cell_reg.valid && right_e.valid)
                    cell_next = right_e;
                else if (cell_reg.valid && !left_e.valid)
                    cell_next.valid = 1'b0;
            end
            OP_SHIFT: cell_next = right_e;
            OP_INSERT:
            begin
                if (left_gt)
                    cell_next = left_e;
                else if (self_gt)
                    cell_next = ctl.fresh;
            end
            default: cell_next = cell_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else
            cell_reg <= cell_next;
    end

endmodule

/* design/sorted_software_timer_queue_top.sv */
// sorted timer queue: set-up writes period and mode on acceptance; start runs
// mark, TIMER_COUNT-1 compaction steps, insert; tick emits each fired timer,
// then reinserts the periodic ones; one result per cycle when out_ready
// holds. one item at a time, in_ready only while the sequencer is idle.
// reset (async, rst_n low) empties the queue, zeroes tick, periods and modes.
// depends on sttq_pkg, sttq_cell
module sorted_software_timer_queue_top #(
    parameter int unsigned TIMER_COUNT = sttq_pkg::TIMER_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                cmd,
    input  logic [sttq_pkg::ID_W-1:0] timer_id,
    input  logic [sttq_pkg::DL_W-1:0] period_value,
    input  logic                      periodic,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [sttq_pkg::ID_W-1:0] fired_timer,
    output logic                      last_fire
);
    import sttq_pkg::*;

    localparam int unsigned NCELL = TIMER_COUNT;
    localparam int unsigned ID_N  = (TIMER_COUNT < (1 << ID_W)) ? TIMER_COUNT : (1 << ID_W);
    localparam int unsigned IDW   = $clog2(ID_N);
    localparam int unsigned PW    = $clog2(ID_N + 1);
    localparam int unsigned CW    = $clog2(NCELL);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_MARK    = 6'b000010,
        S_COMPACT = 6'b000100,
        S_INSERT  = 6'b001000,
        S_FIRE    = 6'b010000,
        S_RELOAD  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [DL_W-1:0]   tick_reg;
    logic [DL_W-1:0]   dl_reg;
    logic [ID_W-1:0]   id_reg;
    logic [CW-1:0]     cnt_reg;
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [DL_W-1:0]   period_mem [ID_N];
    logic              mode_reg [ID_N];
    logic [ID_W-1:0]   fire_list [ID_N];
    logic              out_valid_reg;
    logic [ID_W-1:0]   fired_reg;
    logic              last_reg;

    entry_t            cell_e  [NCELL];
    logic              cell_gt [NCELL];
    logic [NCELL-1:0]  valid_vec;
    cell_ctl_t         ctl;

    logic              accept, id_ok, expired0, expired1, emit, more;
    logic [IDW-1:0]    rd_idx;
    logic [DL_W-1:0]   period_rd;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign id_ok       = (32'(timer_id) < 32'(TIMER_COUNT));
    assign out_valid   = out_valid_reg;
    assign fired_timer = fired_reg;
    assign last_fire   = last_reg;

    assign expired0 = cell_e[0].valid && (cell_e[0].deadline <= tick_reg);
    assign expired1 = cell_e[1].valid && (cell_e[1].deadline <= tick_reg);
    assign emit     = (state_reg == S_FIRE) && expired0 && (!out_valid_reg || out_ready);
    assign more     = (rd_ptr_reg != wr_ptr_reg);

    // one period read port, shared by start and periodic reload
    assign rd_idx    = (state_reg == S_IDLE) ? timer_id[IDW-1:0]
                                             : fire_list[rd_ptr_reg[IDW-1:0]][IDW-1:0];
    assign period_rd = period_mem[rd_idx];

    always_comb
    begin
        ctl.op    = OP_HOLD;
        ctl.key   = id_reg;
        ctl.fresh = '{valid: 1'b1, deadline: dl_reg, owner: id_reg};
        unique case (state_reg)
            S_MARK:    ctl.op = OP_MARK;
            S_COMPACT: ctl.op = OP_COMPACT;
            S_INSERT:  ctl.op = OP_INSERT;
            S_FIRE:    ctl.op = emit ? OP_SHIFT : OP_HOLD;
            default:   ctl.op = OP_HOLD;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            entry_t left_e, right_e;
            logic   left_gt;
            if (g == 0)
            begin : g_head
                assign left_e  = '{valid: 1'b1, deadline: '0, owner: '0};
                assign left_gt = 1'b0;
            end
            else
            begin : g_body
                assign left_e  = cell_e[g-1];
                assign left_gt = cell_gt[g-1];
            end
            if (g == NCELL - 1)
            begin : g_tail
                assign right_e = '0;
            end
            else
            begin : g_mid
                assign right_e = cell_e[g+1];
            end
            sttq_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .left_e  (left_e),
                .left_gt (left_gt),
                .right_e (right_e),
                .self_e  (cell_e[g]),
                .self_gt (cell_gt[g])
            );
            assign valid_vec[g] = cell_e[g].valid;
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_TICK)
                        state_next = S_FIRE;
                    else if (cmd == CMD_START && id_ok)
                        state_next = S_MARK;
                end
            end
            S_MARK:    state_next = S_COMPACT;
            S_COMPACT:
            begin
                if (32'(cnt_reg) >= 32'(NCELL - 2))
                    state_next = S_INSERT;
            end
            S_INSERT:  state_next = more ? S_RELOAD : S_IDLE;
            S_FIRE:
            begin
                if (!expired0)
                    state_next = more ? S_RELOAD : S_IDLE;
            end
            S_RELOAD:  state_next = S_INSERT;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            cnt_reg       <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ID_N; i++)
            begin
                period_mem[i] <= '0;
                mode_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept && cmd == CMD_TICK)
            begin
                tick_reg   <= tick_reg + 1'b1;
                wr_ptr_reg <= '0;
                rd_ptr_reg <= '0;
            end
            if (accept && cmd == CMD_SETUP && id_ok)
            begin
                period_mem[timer_id[IDW-1:0]] <= period_value;
                mode_reg[timer_id[IDW-1:0]]   <= periodic;
            end
            if (state_reg == S_MARK)
                cnt_reg <= '0;
            else if (state_reg == S_COMPACT)
                cnt_reg <= cnt_reg + 1'b1;
            if (emit && mode_reg[cell_e[0].owner[IDW-1:0]])
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (state_reg == S_RELOAD)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_START && id_ok)
        begin
            id_reg <= timer_id;
            dl_reg <= tick_reg + period_rd;
        end
        if (state_reg == S_RELOAD)
        begin
            id_reg <= fire_list[rd_ptr_reg[IDW-1:0]];
            dl_reg <= tick_reg + period_rd;
        end
        if (emit)
        begin
            fired_reg <= cell_e[0].owner;
            last_reg  <= !expired1;
            if (mode_reg[cell_e[0].owner[IDW-1:0]])
                fire_list[wr_ptr_reg[IDW-1:0]] <= cell_e[0].owner;
        end
    end

    // valid cells form a prefix whenever the queue is at rest
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((valid_vec & (valid_vec + 1'b1)) == '0))
        else $error("queue has a hole while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd == CMD_TICK) |=> (state_reg == S_FIRE))
        else $error("tick transfer did not start the fire scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIRE))
        else $error("result produced outside the fire scan");

endmodule
